### src/qni_pkg.sv
// Shared beat types, status codes and saturation helper for the quadratic Newton interpolator.
package qni_pkg;

    typedef struct packed {
        logic signed [31:0] query_x;
        logic signed [31:0] knot_x_first;
        logic signed [31:0] knot_x_second;
        logic signed [31:0] knot_x_third;
        logic signed [31:0] knot_y_first;
        logic signed [31:0] knot_y_second;
        logic signed [31:0] knot_y_third;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic [1:0]         status;
    } t_out_beat;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DIV = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32 = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } t_sat_val;

    // Sideband carried alongside the first divider pair.
    typedef struct packed {
        logic signed [31:0] h31;
        logic signed [31:0] dx1;
        logic signed [31:0] dx2;
        logic signed [31:0] f1;
        logic               sat;
        logic               zero;
        logic               valid;
    } t_side_a;

    // Sideband carried alongside the second divider.
    typedef struct packed {
        logic signed [31:0] b2;
        logic signed [31:0] dx1;
        logic signed [31:0] dx2;
        logic signed [31:0] f1;
        logic               sat;
        logic               zero;
        logic               valid;
    } t_side_b;

    // Clamps a wide signed value to the 32-bit range and flags clamping.
    function automatic t_sat_val sat32(input logic signed [63:0] v);
        t_sat_val res;
        if (v > 64'(MAX32)) begin
            res.val = MAX32;
            res.sat = 1'b1;
        end else if (v < 64'(MIN32)) begin
            res.val = MIN32;
            res.sat = 1'b1;
        end else begin
            res.val = v[31:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

endpackage

### src/quadratic_newton_interpolator.sv
// Top level of the pipelined quadratic Newton interpolator.
// This block evaluates the quadratic through three knots at a query point using Newton
// divided differences, in signed fixed point with FRAC_BITS fraction bits. It accepts one
// beat every cycle while o_stall is low and returns exactly one result beat per input beat,
// in order. The pipeline is built around the two chained bit-per-stage dividers, each
// FRAC_BITS + 34 stages deep, with the difference, multiply and add stages around them.
// The whole pipeline advances together:
// when the output beat is held by i_stall, o_stall is raised and nothing moves, so no beat
// is lost or repeated. A zero knot spacing gives value 0 with the zero-divisor status, which
// wins over saturation; any clamped intermediate or result gives the saturation status.
module quadratic_newton_interpolator import qni_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    localparam int SWA = $bits(t_side_a);
    localparam int SWB = $bits(t_side_b);

    // The pipeline moves as one unless a finished beat is waiting downstream.
    logic r_out_valid;
    logic n_en;
    assign n_en    = !(r_out_valid && i_stall);
    assign o_stall = !n_en;

    // Stage 1: all the knot and query differences, each saturated.
    t_sat_val n_h21, n_h32, n_h31, n_d21, n_d32, n_dx1, n_dx2;

    always_comb begin
        n_h21 = sat32(64'(i_data.knot_x_second) - 64'(i_data.knot_x_first));
        n_h32 = sat32(64'(i_data.knot_x_third)  - 64'(i_data.knot_x_second));
        n_h31 = sat32(64'(i_data.knot_x_third)  - 64'(i_data.knot_x_first));
        n_d21 = sat32(64'(i_data.knot_y_second) - 64'(i_data.knot_y_first));
        n_d32 = sat32(64'(i_data.knot_y_third)  - 64'(i_data.knot_y_second));
        n_dx1 = sat32(64'(i_data.query_x)       - 64'(i_data.knot_x_first));
        n_dx2 = sat32(64'(i_data.query_x)       - 64'(i_data.knot_x_second));
    end

    logic signed [31:0] r_s1_h21, r_s1_h32, r_s1_d21, r_s1_d32;
    t_side_a            r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side.valid <= 1'b0;
        end else if (n_en) begin
            r_s1_side.valid <= i_valid;
        end
        if (n_en) begin
            r_s1_h21       <= n_h21.val;
            r_s1_h32       <= n_h32.val;
            r_s1_d21       <= n_d21.val;
            r_s1_d32       <= n_d32.val;
            r_s1_side.h31  <= n_h31.val;
            r_s1_side.dx1  <= n_dx1.val;
            r_s1_side.dx2  <= n_dx2.val;
            r_s1_side.f1   <= i_data.knot_y_first;
            r_s1_side.sat  <= n_h21.sat | n_h32.sat | n_h31.sat | n_d21.sat
                            | n_d32.sat | n_dx1.sat | n_dx2.sat;
            r_s1_side.zero <= (n_h21.val == '0) || (n_h32.val == '0) || (n_h31.val == '0);
        end
    end

    // First divider pair: b2 and the second-interval slope, side by side.
    logic signed [31:0] w_b2, w_q32;
    logic               w_b2_sat, w_q32_sat;
    logic [SWA-1:0]     w_side_a_raw;
    logic               w_q32_valid;
    t_side_a            w_side_a;

    qni_div #(.FRAC_BITS(FRAC_BITS), .SW(SWA)) u_div_b2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (n_en),
        .i_num  (r_s1_d21),
        .i_den  (r_s1_h21),
        .i_side (r_s1_side),
        .o_quo  (w_b2),
        .o_sat  (w_b2_sat),
        .o_side (w_side_a_raw)
    );

    qni_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_q32 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (n_en),
        .i_num  (r_s1_d32),
        .i_den  (r_s1_h32),
        .i_side (r_s1_side.valid),
        .o_quo  (w_q32),
        .o_sat  (w_q32_sat),
        .o_side (w_q32_valid)
    );

    assign w_side_a = t_side_a'(w_side_a_raw);

    // Stage after the pair: the numerator of the second divided difference.
    t_sat_val n_num;
    assign n_num = sat32(64'(w_q32) - 64'(w_b2));

    logic signed [31:0] r_p1_num, r_p1_h31;
    t_side_b            r_p1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_side.valid <= 1'b0;
        end else if (n_en) begin
            r_p1_side.valid <= w_side_a.valid;
        end
        if (n_en) begin
            r_p1_num       <= n_num.val;
            r_p1_h31       <= w_side_a.h31;
            r_p1_side.b2   <= w_b2;
            r_p1_side.dx1  <= w_side_a.dx1;
            r_p1_side.dx2  <= w_side_a.dx2;
            r_p1_side.f1   <= w_side_a.f1;
            r_p1_side.sat  <= w_side_a.sat | w_b2_sat | w_q32_sat | n_num.sat;
            r_p1_side.zero <= w_side_a.zero;
        end
    end

    // Second divider: b3.
    logic signed [31:0] w_b3;
    logic               w_b3_sat;
    logic [SWB-1:0]     w_side_b_raw;
    t_side_b            w_side_b;

    qni_div #(.FRAC_BITS(FRAC_BITS), .SW(SWB)) u_div_b3 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (n_en),
        .i_num  (r_p1_num),
        .i_den  (r_p1_h31),
        .i_side (r_p1_side),
        .o_quo  (w_b3),
        .o_sat  (w_b3_sat),
        .o_side (w_side_b_raw)
    );

    assign w_side_b = t_side_b'(w_side_b_raw);

    // Multiply stages. Each full product is registered before it is scaled back.
    logic signed [63:0] r_p2_t1p, r_p2_t2p;
    logic signed [31:0] r_p2_b3, r_p2_f1;
    logic               r_p2_sat, r_p2_zero, r_p2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (n_en) begin
            r_p2_valid <= w_side_b.valid;
        end
        if (n_en) begin
            r_p2_t1p  <= 64'(w_side_b.b2) * 64'(w_side_b.dx1);
            r_p2_t2p  <= 64'(w_side_b.dx1) * 64'(w_side_b.dx2);
            r_p2_b3   <= w_b3;
            r_p2_f1   <= w_side_b.f1;
            r_p2_sat  <= w_side_b.sat | w_b3_sat;
            r_p2_zero <= w_side_b.zero;
        end
    end

    t_sat_val n_t1, n_t2;
    assign n_t1 = sat32(r_p2_t1p >>> FRAC_BITS);
    assign n_t2 = sat32(r_p2_t2p >>> FRAC_BITS);

    logic signed [31:0] r_p3_t1, r_p3_t2, r_p3_b3, r_p3_f1;
    logic               r_p3_sat, r_p3_zero, r_p3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (n_en) begin
            r_p3_valid <= r_p2_valid;
        end
        if (n_en) begin
            r_p3_t1   <= n_t1.val;
            r_p3_t2   <= n_t2.val;
            r_p3_b3   <= r_p2_b3;
            r_p3_f1   <= r_p2_f1;
            r_p3_sat  <= r_p2_sat | n_t1.sat | n_t2.sat;
            r_p3_zero <= r_p2_zero;
        end
    end

    logic signed [63:0] r_p4_t3p;
    logic signed [31:0] r_p4_t1, r_p4_f1;
    logic               r_p4_sat, r_p4_zero, r_p4_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else if (n_en) begin
            r_p4_valid <= r_p3_valid;
        end
        if (n_en) begin
            r_p4_t3p  <= 64'(r_p3_b3) * 64'(r_p3_t2);
            r_p4_t1   <= r_p3_t1;
            r_p4_f1   <= r_p3_f1;
            r_p4_sat  <= r_p3_sat;
            r_p4_zero <= r_p3_zero;
        end
    end

    // Scale the last product and form the sum of the two correction terms.
    t_sat_val n_t3, n_s;
    assign n_t3 = sat32(r_p4_t3p >>> FRAC_BITS);
    assign n_s  = sat32(64'(r_p4_t1) + 64'(n_t3.val));

    logic signed [31:0] r_p5_s, r_p5_f1;
    logic               r_p5_sat, r_p5_zero, r_p5_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
        end else if (n_en) begin
            r_p5_valid <= r_p4_valid;
        end
        if (n_en) begin
            r_p5_s    <= n_s.val;
            r_p5_f1   <= r_p4_f1;
            r_p5_sat  <= r_p4_sat | n_t3.sat | n_s.sat;
            r_p5_zero <= r_p4_zero;
        end
    end

    // Output register: final add, then the zero-divisor override.
    t_sat_val  n_r;
    t_out_beat n_out;
    t_out_beat r_out;

    always_comb begin
        n_r = sat32(64'(r_p5_f1) + 64'(r_p5_s));
        if (r_p5_zero) begin
            n_out.interpolated_value = '0;
            n_out.status             = ST_ZERO_DIV;
        end else begin
            n_out.interpolated_value = n_r.val;
            n_out.status             = (r_p5_sat || n_r.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r_out_valid <= r_p5_valid;
        end
        if (n_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // The two lanes of the first divider pair always carry the same beat.
    a_pair_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q32_valid == w_side_a.valid)
        else $error("divider lanes out of step");

    // A zero-divisor result always reads as zero.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_ZERO_DIV) |-> (o_data.interpolated_value == '0))
        else $error("zero-divisor beat with nonzero value");

    // The pipeline only freezes while a finished beat waits.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a waiting output beat");

endmodule

### src/qni_div.sv
// Pipelined restoring divider computing (a << FRAC_BITS) / b, one quotient bit per stage.
module qni_div import qni_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    input  logic [SW-1:0]      i_side,
    output logic signed [31:0] o_quo,
    output logic               o_sat,
    output logic [SW-1:0]      o_side
);

    localparam int QW = 32 + FRAC_BITS;

    logic [31:0]    r_rem  [0:QW];
    logic [QW-1:0]  r_dvd  [0:QW];
    logic [QW-1:0]  r_quo  [0:QW];
    logic [31:0]    r_mb   [0:QW];
    logic           r_neg  [0:QW];
    logic [SW-1:0]  r_side [0:QW];

    logic [31:0] n_ma;
    logic [31:0] n_mb;

    assign n_ma = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign n_mb = i_den[31] ? 32'(-i_den) : 32'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
        end
        if (i_en) begin
            r_rem[0] <= '0;
            r_dvd[0] <= QW'(n_ma) << FRAC_BITS;
            r_quo[0] <= '0;
            r_mb[0]  <= n_mb;
            r_neg[0] <= i_num[31] ^ i_den[31];
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [32:0] n_trial;
        logic        n_ge;
        assign n_trial = {r_rem[k-1], r_dvd[k-1][QW-1]};
        assign n_ge    = n_trial >= {1'b0, r_mb[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else if (i_en) begin
                r_side[k] <= r_side[k-1];
            end
            if (i_en) begin
                r_rem[k] <= n_ge ? 32'(n_trial - {1'b0, r_mb[k-1]}) : n_trial[31:0];
                r_dvd[k] <= r_dvd[k-1] << 1;
                r_quo[k] <= {r_quo[k-1][QW-2:0], n_ge};
                r_mb[k]  <= r_mb[k-1];
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // The magnitude may reach 2^31 only on the negative side.
    localparam logic [QW-1:0] NEG_LIM = QW'(1) << 31;
    localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

    logic signed [31:0] n_quo;
    logic               n_sat;

    always_comb begin
        if (r_neg[QW]) begin
            n_sat = r_quo[QW] > NEG_LIM;
            n_quo = n_sat ? MIN32 : 32'(-r_quo[QW][31:0]);
        end else begin
            n_sat = r_quo[QW] > POS_LIM;
            n_quo = n_sat ? MAX32 : r_quo[QW][31:0];
        end
    end

    logic signed [31:0] r_quo_out;
    logic               r_sat_out;
    logic [SW-1:0]      r_side_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_out <= '0;
        end else if (i_en) begin
            r_side_out <= r_side[QW];
        end
        if (i_en) begin
            r_quo_out <= n_quo;
            r_sat_out <= n_sat;
        end
    end

    assign o_quo  = r_quo_out;
    assign o_sat  = r_sat_out;
    assign o_side = r_side_out;

endmodule

### sim/quadratic_newton_interpolator_test.sv
// Self-checking testbench for the quadratic Newton interpolator.
`timescale 1ns / 1ps

module quadratic_newton_interpolator_test;
    import qni_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 2 * FRAC + 75;
    localparam int RANDOM_BEATS = 1300;
    localparam longint CYCLE_LIMIT = 400000;

    // Predicts interpolated results and checks the block's output beats in order.
    class interp_scoreboard;
        t_out_beat pending_results[$];
        int        error_count;

        // Clamps to the signed 32-bit range and records any clamping.
        function automatic longint clamp32(longint v, ref bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // Fixed-point product; the arithmetic shift rounds toward minus infinity.
        function automatic longint fixed_mul(longint a, longint b, ref bit sat);
            longint p;
            p = a * b;
            return clamp32(p >>> FRAC, sat);
        endfunction

        // Fixed-point quotient, truncated toward zero; the divisor is nonzero.
        function automatic longint fixed_div(longint a, longint b, ref bit sat);
            longint ma;
            longint mb;
            longint q;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            q = (ma <<< FRAC) / mb;
            if ((a < 0) != (b < 0)) q = -q;
            return clamp32(q, sat);
        endfunction

        function automatic t_out_beat interpolate(t_in_beat beat);
            t_out_beat res;
            bit        sat;
            longint    h21, h32, h31, b2, q32, b3, dx1, dx2, t1, t2, t3, s;
            sat = 1'b0;
            h21 = clamp32(longint'(beat.knot_x_second) - beat.knot_x_first, sat);
            h32 = clamp32(longint'(beat.knot_x_third) - beat.knot_x_second, sat);
            h31 = clamp32(longint'(beat.knot_x_third) - beat.knot_x_first, sat);
            if (h21 == 0 || h32 == 0 || h31 == 0) begin
                res.interpolated_value = '0;
                res.status = ST_ZERO_DIV;
                return res;
            end
            b2 = fixed_div(clamp32(longint'(beat.knot_y_second) - beat.knot_y_first, sat),
                           h21, sat);
            q32 = fixed_div(clamp32(longint'(beat.knot_y_third) - beat.knot_y_second, sat),
                            h32, sat);
            b3 = fixed_div(clamp32(q32 - b2, sat), h31, sat);
            dx1 = clamp32(longint'(beat.query_x) - beat.knot_x_first, sat);
            dx2 = clamp32(longint'(beat.query_x) - beat.knot_x_second, sat);
            t1 = fixed_mul(b2, dx1, sat);
            t2 = fixed_mul(dx1, dx2, sat);
            t3 = fixed_mul(b3, t2, sat);
            s = clamp32(t1 + t3, sat);
            res.interpolated_value = 32'(clamp32(longint'(beat.knot_y_first) + s, sat));
            res.status = sat ? ST_SAT : ST_OK;
            return res;
        endfunction

        function void note_input(t_in_beat beat);
            pending_results.push_back(interpolate(beat));
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d status=%0d", $time,
                         got.interpolated_value, got.status);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.interpolated_value !== want.interpolated_value) begin
                $display("%0t: value mismatch expected=%0d actual=%0d", $time,
                         want.interpolated_value, got.interpolated_value);
                error_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                         want.status, got.status);
                error_count++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_data;

    interp_scoreboard scoreboard;
    longint           cycle_count;
    // While set, both sides run without idling or stalling.
    bit               no_idle;

    quadratic_newton_interpolator #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        scoreboard = new();
        cycle_count = 0;
        no_idle = 1'b0;
    end

    // A beat leaves the block whenever valid is high and we are not stalling.
    // The stall for the next cycle is drawn at every edge, about 13 in a hundred.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall) scoreboard.check_result(out_data);
        out_stall <= rst_n && !no_idle && ($urandom_range(99) < 13);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quadratic_newton_interpolator regression: fail");
            $finish;
        end
    end

    // Presents one input beat, possibly after a random idle gap, and holds it until
    // the block takes it. The beat is noted for prediction at its accepting edge.
    task automatic send_beat(t_in_beat beat);
        while (!no_idle && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        scoreboard.note_input(beat);
    endtask

    // Values that often hit the range ends, zero or small whole numbers, otherwise fully random.
    function automatic logic [31:0] edgy_word();
        unique case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(8)) - 4) <<< FRAC;
            default: return $urandom;
        endcase
    endfunction

    // Knots that are well separated and modest, so most beats avoid saturation.
    function automatic t_in_beat tame_beat();
        t_in_beat b;
        logic signed [31:0] base;
        base = $signed($urandom_range(2000)) - 1000;
        b.knot_x_first = (base) <<< 8;
        b.knot_x_second = (base + 1 + $signed($urandom_range(200))) <<< 8;
        b.knot_x_third = (base + 300 + $signed($urandom_range(200))) <<< 8;
        b.query_x = (base + $signed($urandom_range(600)) - 100) <<< 8;
        b.knot_y_first = $signed($urandom_range(32'h0fffffff)) - 32'sh08000000;
        b.knot_y_second = $signed($urandom_range(32'h0fffffff)) - 32'sh08000000;
        b.knot_y_third = $signed($urandom_range(32'h0fffffff)) - 32'sh08000000;
        return b;
    endfunction

    function automatic t_in_beat wild_beat();
        t_in_beat b;
        b.query_x = edgy_word();
        b.knot_x_first = edgy_word();
        b.knot_x_second = edgy_word();
        b.knot_x_third = edgy_word();
        b.knot_y_first = edgy_word();
        b.knot_y_second = edgy_word();
        b.knot_y_third = edgy_word();
        // Sometimes repeat an abscissa to provoke the zero-divisor status.
        if ($urandom_range(9) == 0) b.knot_x_third = b.knot_x_first;
        return b;
    endfunction

    initial begin
        t_in_beat b;
        int       waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: plain quadratic, each pair of equal abscissas, range ends.
        b = '{query_x: 32'sh00018000, knot_x_first: 32'sh0, knot_x_second: 32'sh00010000,
              knot_x_third: 32'sh00020000, knot_y_first: 32'sh0,
              knot_y_second: 32'sh00010000, knot_y_third: 32'sh00040000};
        send_beat(b);
        b.knot_x_second = b.knot_x_first;
        send_beat(b);
        b.knot_x_second = 32'sh00010000;
        b.knot_x_third = b.knot_x_second;
        send_beat(b);
        b.knot_x_third = b.knot_x_first;
        send_beat(b);
        // Spacing that saturates on the subtraction still counts as nonzero.
        b.knot_x_first = 32'sh80000000;
        b.knot_x_second = 32'sh7fffffff;
        b.knot_x_third = 32'sh0;
        send_beat(b);
        b = '{default: 32'sh7fffffff};
        send_beat(b);
        b = '{default: 32'sh80000000};
        send_beat(b);
        b = '{query_x: 32'sh7fffffff, knot_x_first: 32'sh80000000, knot_x_second: 32'sh1,
              knot_x_third: 32'sh2, knot_y_first: 32'sh7fffffff,
              knot_y_second: 32'sh80000000, knot_y_third: 32'sh7fffffff};
        send_beat(b);
        b = '{query_x: 32'shffffffff, knot_x_first: 32'sh0, knot_x_second: 32'sh1,
              knot_x_third: 32'shffffffff, knot_y_first: 32'shffffffff,
              knot_y_second: 32'sh1, knot_y_third: 32'sh0};
        send_beat(b);
        for (int i = 0; i < 12; i++) send_beat(wild_beat());

        // Random part: mostly tame knots, the rest edge-heavy noise, with a stretch
        // in the middle where neither side idles.
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            no_idle = (i >= 500 && i < 750);
            if ($urandom_range(99) < 70) send_beat(tame_beat());
            else send_beat(wild_beat());
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        waited = 0;
        while (scoreboard.pending_results.size() != 0 && waited < 100 * LATENCY) begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (scoreboard.error_count == 0 && scoreboard.pending_results.size() == 0) begin
            $display("quadratic_newton_interpolator regression: pass");
        end else begin
            $display("quadratic_newton_interpolator regression: fail");
        end
        $finish;
    end

endmodule
